### hdl/scwu_pkg.sv
package scwu_pkg;

  // default channel count and field widths
  localparam int CHANNELS_DEF = 16;
  localparam int OP_W         = 3;
  localparam int CHAN_W       = 4;
  localparam int TASK_W       = 8;
  localparam int STAT_W       = 2;
  localparam int CNT_W        = 8;

  // task number that marks an empty waiter slot
  localparam logic [TASK_W-1:0] NO_TASK = 8'hff;

  // request codes
  localparam logic [OP_W-1:0] OP_SEND    = 3'd0;
  localparam logic [OP_W-1:0] OP_WAIT    = 3'd1;
  localparam logic [OP_W-1:0] OP_COLLECT = 3'd2;
  localparam logic [OP_W-1:0] OP_CLEAR   = 3'd3;
  localparam logic [OP_W-1:0] OP_CHECK   = 3'd4;

  // response status codes
  localparam logic [STAT_W-1:0] ST_OK      = 2'd0;
  localparam logic [STAT_W-1:0] ST_FULL    = 2'd1;
  localparam logic [STAT_W-1:0] ST_BLOCKED = 2'd2;

  typedef struct packed {
    logic [OP_W-1:0]   op;
    logic [CHAN_W-1:0] channel;
    logic [TASK_W-1:0] task_id;
  } req_t;

  typedef struct packed {
    logic [STAT_W-1:0] status;
    logic [CNT_W-1:0]  count;
    logic              wake_valid;
    logic [TASK_W-1:0] wake_task;
  } rsp_t;

  // one channel entry as held in the state memory
  typedef struct packed {
    logic [CNT_W-1:0]  produced;
    logic [CNT_W-1:0]  consumed;
    logic [TASK_W-1:0] waiter;
  } ent_t;

  localparam ent_t ENT_RESET = '{produced: '0, consumed: '0, waiter: NO_TASK};

endpackage

### hdl/scwu_chan_if.sv
// request channel
interface scwu_req_if;
  import scwu_pkg::*;
  logic valid;
  logic ready;
  req_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// response channel
interface scwu_rsp_if;
  import scwu_pkg::*;
  logic valid;
  logic ready;
  rsp_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

### hdl/signal_counter_wake_unit_core.sv
// channel   | direction | word
// ----------+-----------+-----------------------------------------------
// in_chan   | in        | op, channel, task_id
// out_chan  | out       | status, count, wake_valid, wake_task
//
// one word per cycle sustained; a result passes the read stage and the output
// register; the rate is set by the read-modify-write of the channel state
// memory, which reads in the accept cycle and writes back as the result enters
// the output register (same-entry overlap is forwarded); reset is synchronous
// and clears one valid bit per channel, so no clearing pass is needed; a
// stalled result holds the compute stage, which then holds the request side
module signal_counter_wake_unit_core #(
  parameter int CHANNELS = scwu_pkg::CHANNELS_DEF
) (
  input logic      clk,
  input logic      rst_n,
  scwu_req_if.sink   in_chan,
  scwu_rsp_if.source out_chan
);
  import scwu_pkg::*;

  // only the first 2**CHAN_W channels are addressable
  localparam int DEPTH = (CHANNELS < (1 << CHAN_W)) ? CHANNELS : (1 << CHAN_W);
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam logic [8:0] CH_LIM = 9'(CHANNELS);

  // state memory and per-entry valid bits
  ent_t             mem [DEPTH];
  logic [DEPTH-1:0] vld_r;

  // read stage registers
  logic              busy_r;
  logic [OP_W-1:0]   op_r;
  logic [TASK_W-1:0] task_r;
  logic [AW-1:0]     idx_r;
  logic              rng_r;
  logic              ent_vld_r;
  logic              fwd_r;
  ent_t              fwd_q_r;
  ent_t              rd_q_r;

  // output register
  logic out_valid_r;
  rsp_t rsp_r;

  logic          in_acc;
  logic          fire;
  logic          wr_en;
  logic [AW-1:0] in_idx;
  logic          in_rng;
  ent_t          cur;
  ent_t          ent_nxt;
  rsp_t          rsp_nxt;
  logic [CNT_W-1:0] pending;

  // handshake
  assign fire          = busy_r && (!out_valid_r || out_chan.ready);
  assign in_chan.ready = !busy_r || fire;
  assign in_acc        = in_chan.valid && in_chan.ready;
  assign in_idx        = in_chan.data.channel[AW-1:0];
  assign in_rng        = {5'b0, in_chan.data.channel} < CH_LIM;
  assign wr_en         = fire && rng_r;

  assign out_chan.valid = out_valid_r;
  assign out_chan.data  = rsp_r;

  // memory write and registered read
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[idx_r] <= ent_nxt;
    end
    if (in_acc) begin
      rd_q_r <= mem[in_idx];
    end
  end

  // read stage control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      vld_r  <= '0;
      fwd_r  <= 1'b0;
    end else begin
      if (in_acc) begin
        busy_r <= 1'b1;
        fwd_r  <= wr_en && (idx_r == in_idx);
      end else if (fire) begin
        busy_r <= 1'b0;
      end
      if (wr_en) begin
        vld_r[idx_r] <= 1'b1;
      end
    end
  end

  // read stage payload
  always_ff @(posedge clk) begin
    if (in_acc) begin
      op_r      <= in_chan.data.op;
      task_r    <= in_chan.data.task_id;
      idx_r     <= in_idx;
      rng_r     <= in_rng;
      ent_vld_r <= vld_r[in_idx];
      fwd_q_r   <= ent_nxt;
    end
  end

  // current entry: forwarded write, stored value, or reset value
  always_comb begin
    if (fwd_r) begin
      cur = fwd_q_r;
    end else if (ent_vld_r) begin
      cur = rd_q_r;
    end else begin
      cur = ENT_RESET;
    end
  end

  assign pending = cur.produced - cur.consumed;

  // request evaluation
  always_comb begin
    ent_nxt = cur;
    rsp_nxt = '0;
    case (op_r)
      OP_SEND: begin
        if (8'(cur.produced + 8'd1) == cur.consumed) begin
          rsp_nxt.status = ST_FULL;
        end else begin
          ent_nxt.produced = 8'(cur.produced + 8'd1);
          if (cur.waiter != NO_TASK) begin
            rsp_nxt.wake_valid = 1'b1;
            rsp_nxt.wake_task  = cur.waiter;
            ent_nxt.waiter     = NO_TASK;
          end
        end
      end
      OP_WAIT: begin
        if (pending == '0) begin
          ent_nxt.waiter = task_r;
          rsp_nxt.status = ST_BLOCKED;
        end else begin
          ent_nxt.waiter   = NO_TASK;
          rsp_nxt.count    = pending;
          ent_nxt.consumed = 8'(cur.consumed + 8'd1);
        end
      end
      OP_COLLECT: begin
        ent_nxt.waiter = NO_TASK;
        rsp_nxt.count  = pending;
        if (pending != '0) begin
          ent_nxt.consumed = 8'(cur.consumed + 8'd1);
        end
      end
      OP_CLEAR: begin
        ent_nxt.consumed = cur.produced;
      end
      OP_CHECK: begin
        rsp_nxt.count = pending;
      end
      default: begin
        ent_nxt = cur;
      end
    endcase
    // out-of-range channel answers all zero
    if (!rng_r) begin
      rsp_nxt = '0;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (fire) begin
      out_valid_r <= 1'b1;
    end else if (out_chan.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      rsp_r <= rsp_nxt;
    end
  end

`ifndef ASSERT_OFF
  // an accepted word always occupies the read stage next cycle
  a_acc_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc |=> busy_r)
    else $error("accepted word did not enter read stage");

  // forwarding is set exactly when an accept overlaps a same-entry write-back
  a_fwd_src: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc |=> (fwd_r == $past(wr_en && (idx_r == in_idx))))
    else $error("forward flag does not match overlapping write");

  // a refused send never wakes a task
  a_full_nowake: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> !(rsp_r.status == ST_FULL && rsp_r.wake_valid))
    else $error("full status with wake");

  // a wake always names a real task
  a_wake_task: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && rsp_r.wake_valid) |-> (rsp_r.wake_task != NO_TASK))
    else $error("wake of empty waiter");
`endif

endmodule

### tb/testbench.sv
module testbench;
  import scwu_pkg::*;

  localparam int CHANNELS = CHANNELS_DEF;
  localparam int QUIET_LIMIT = 1000;
  localparam int SETTLE_CYCLES = 10;

  // request codes the block ignores
  localparam logic [OP_W-1:0] OP_RSVD_A = 3'd5;
  localparam logic [OP_W-1:0] OP_RSVD_B = 3'd6;
  localparam logic [OP_W-1:0] OP_RSVD_C = 3'd7;

  logic clk = 1'b0;
  logic rst_n;

  scwu_req_if in_chan ();
  scwu_rsp_if out_chan ();

  signal_counter_wake_unit_core #(.CHANNELS(CHANNELS)) uut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (in_chan),
    .out_chan (out_chan)
  );

  // predicted channel state
  logic [CNT_W-1:0]  produced_cnt [CHANNELS];
  logic [CNT_W-1:0]  consumed_cnt [CHANNELS];
  logic [TASK_W-1:0] waiter_id    [CHANNELS];

  rsp_t        responses_due[$];
  int unsigned err_count = 0;
  int unsigned quiet_cycles = 0;
  bit          idle_on = 1'b1;
  int          rx_hold = 0;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // semaphore behavior for one request, updates the predicted state
  function automatic rsp_t serve_request(req_t r);
    rsp_t             rsp;
    logic [CNT_W-1:0] pend;
    logic [CNT_W-1:0] next_prod;
    int unsigned      ch;
    rsp = '0;
    ch = 32'(r.channel);
    if (ch < CHANNELS) begin
      pend = produced_cnt[ch] - consumed_cnt[ch];
      next_prod = produced_cnt[ch] + 8'd1;
      case (r.op)
        OP_SEND: begin
          if (next_prod == consumed_cnt[ch]) begin
            rsp.status = ST_FULL;
          end else begin
            produced_cnt[ch] = next_prod;
            if (waiter_id[ch] != NO_TASK) begin
              rsp.wake_valid = 1'b1;
              rsp.wake_task = waiter_id[ch];
              waiter_id[ch] = NO_TASK;
            end
          end
        end
        OP_WAIT: begin
          if (pend == 0) begin
            waiter_id[ch] = r.task_id;
            rsp.status = ST_BLOCKED;
          end else begin
            waiter_id[ch] = NO_TASK;
            rsp.count = pend;
            consumed_cnt[ch] = consumed_cnt[ch] + 8'd1;
          end
        end
        OP_COLLECT: begin
          waiter_id[ch] = NO_TASK;
          rsp.count = pend;
          if (pend != 0) consumed_cnt[ch] = consumed_cnt[ch] + 8'd1;
        end
        OP_CLEAR: begin
          consumed_cnt[ch] = produced_cnt[ch];
        end
        OP_CHECK: begin
          rsp.count = pend;
        end
        default: begin
        end
      endcase
    end
    return rsp;
  endfunction

  // offer one request word, predict its response once accepted
  task automatic send_request(input logic [OP_W-1:0] op, input logic [CHAN_W-1:0] ch,
                              input logic [TASK_W-1:0] tid);
    req_t r;
    int   gap;
    r.op = op;
    r.channel = ch;
    r.task_id = tid;
    gap = idle_on ? int'($urandom_range(0, 4)) : 0;
    if (gap > 0) begin
      in_chan.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_chan.valid <= 1'b1;
    in_chan.data <= r;
    do @(posedge clk); while (in_chan.ready !== 1'b1);
    responses_due.push_back(serve_request(r));
  endtask

  task automatic send_random_request();
    int unsigned       pick;
    logic [OP_W-1:0]   op;
    logic [CHAN_W-1:0] ch;
    logic [TASK_W-1:0] tid;
    pick = $urandom_range(0, 99);
    if (pick < 35) op = OP_SEND;
    else if (pick < 60) op = OP_WAIT;
    else if (pick < 72) op = OP_COLLECT;
    else if (pick < 80) op = OP_CLEAR;
    else if (pick < 92) op = OP_CHECK;
    else op = OP_W'($urandom_range(OP_RSVD_A, OP_RSVD_C));
    // favor a few channels so requests interact
    ch = $urandom_range(0, 1) ? CHAN_W'($urandom_range(0, 3))
                              : CHAN_W'($urandom_range(0, CHANNELS - 1));
    tid = ($urandom_range(0, 9) == 0) ? NO_TASK : TASK_W'($urandom_range(0, NO_TASK - 1));
    send_request(op, ch, tid);
  endtask

  // sender goes quiet until every response is back
  task automatic wait_for_responses();
    in_chan.valid <= 1'b0;
    while (responses_due.size() != 0) @(posedge clk);
  endtask

  task automatic test_directed_ops();
    send_request(OP_CHECK, 4'd0, 8'd0);
    send_request(OP_CHECK, 4'd15, 8'd0);
    send_request(OP_COLLECT, 4'd0, 8'd0);
    // blocked wait, then a send wakes the waiter once
    send_request(OP_WAIT, 4'd1, 8'h00);
    send_request(OP_SEND, 4'd1, 8'h00);
    send_request(OP_SEND, 4'd1, 8'h00);
    send_request(OP_WAIT, 4'd1, 8'h05);
    send_request(OP_CHECK, 4'd1, 8'h00);
    send_request(OP_COLLECT, 4'd1, 8'h00);
    send_request(OP_COLLECT, 4'd1, 8'h00);
    send_request(OP_WAIT, 4'd15, 8'hfe);
    send_request(OP_SEND, 4'd15, 8'hff);
    // task 255 reads as no waiter
    send_request(OP_WAIT, 4'd2, NO_TASK);
    send_request(OP_SEND, 4'd2, 8'h00);
    // collect at timeout drops the waiter
    send_request(OP_WAIT, 4'd3, 8'haa);
    send_request(OP_COLLECT, 4'd3, 8'h55);
    send_request(OP_SEND, 4'd3, 8'h00);
    send_request(OP_SEND, 4'd4, 8'h00);
    send_request(OP_SEND, 4'd4, 8'h00);
    send_request(OP_SEND, 4'd4, 8'h00);
    send_request(OP_CLEAR, 4'd4, 8'h00);
    send_request(OP_CHECK, 4'd4, 8'h00);
    send_request(OP_RSVD_A, 4'd15, NO_TASK);
    send_request(OP_RSVD_B, 4'd15, NO_TASK);
    send_request(OP_RSVD_C, 4'd15, NO_TASK);
  endtask

  // fill one channel to 255 pending and push past it
  task automatic test_full_channel();
    logic [CHAN_W-1:0] ch;
    ch = CHAN_W'($urandom_range(0, CHANNELS - 1));
    send_request(OP_CLEAR, ch, 8'h00);
    send_request(OP_WAIT, ch, TASK_W'($urandom_range(0, NO_TASK - 1)));
    repeat (256) send_request(OP_SEND, ch, TASK_W'($urandom_range(0, NO_TASK)));
    send_request(OP_CHECK, ch, 8'h00);
    send_request(OP_WAIT, ch, 8'h10);
    send_request(OP_SEND, ch, 8'h00);
    send_request(OP_SEND, ch, 8'h00);
    send_request(OP_CLEAR, ch, 8'h00);
    send_request(OP_CHECK, ch, 8'h00);
  endtask

  // receiver stalls long while requests keep coming
  task automatic test_receiver_backpressure();
    rx_hold = 80;
    repeat (30) send_random_request();
    wait_for_responses();
  endtask

  // blocked wait, a send that wakes it unless the task is 255, then collect, on a cleared channel
  task automatic run_wake_sequence();
    logic [CHAN_W-1:0] ch;
    logic [TASK_W-1:0] tid;
    ch = CHAN_W'($urandom_range(0, CHANNELS - 1));
    tid = TASK_W'($urandom_range(0, NO_TASK));
    send_request(OP_CLEAR, ch, 8'h00);
    send_request(OP_WAIT, ch, tid);
    send_request(OP_SEND, ch, TASK_W'($urandom_range(0, NO_TASK)));
    send_request(OP_COLLECT, ch, tid);
  endtask

  task automatic test_random_traffic();
    repeat (100) begin
      if ($urandom_range(0, 1)) run_wake_sequence();
      else send_random_request();
    end
  endtask

  // no idling on either side
  task automatic test_back_to_back();
    idle_on = 1'b0;
    repeat (60) send_random_request();
    repeat (5) run_wake_sequence();
    idle_on = 1'b1;
  endtask

  // response side: random stalls plus the long hold
  initial begin
    int gap;
    out_chan.ready <= 1'b0;
    @(posedge clk iff rst_n === 1'b1);
    forever begin
      if (rx_hold > 0) begin
        out_chan.ready <= 1'b0;
        repeat (rx_hold) @(posedge clk);
        rx_hold = 0;
      end
      gap = idle_on ? int'($urandom_range(0, 4)) : 0;
      if (gap > 0) begin
        out_chan.ready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      out_chan.ready <= 1'b1;
      do @(posedge clk); while (out_chan.valid !== 1'b1);
    end
  end

  // compare each response word with the oldest prediction
  always @(posedge clk) begin
    rsp_t got;
    rsp_t want;
    if (rst_n === 1'b1 && out_chan.valid === 1'b1 && out_chan.ready === 1'b1) begin
      got = out_chan.data;
      if (responses_due.size() == 0) begin
        $display("%0t: unexpected response word %h", $time, got);
        err_count++;
      end else begin
        want = responses_due.pop_front();
        if (got.status !== want.status) begin
          $display("%0t: status expected %0d, got %0d", $time, want.status, got.status);
          err_count++;
        end
        if (got.count !== want.count) begin
          $display("%0t: count expected %0d, got %0d", $time, want.count, got.count);
          err_count++;
        end
        if (got.wake_valid !== want.wake_valid) begin
          $display("%0t: wake_valid expected %0d, got %0d", $time, want.wake_valid,
                   got.wake_valid);
          err_count++;
        end
        if (got.wake_task !== want.wake_task) begin
          $display("%0t: wake_task expected %0d, got %0d", $time, want.wake_task,
                   got.wake_task);
          err_count++;
        end
      end
    end
  end

  // watchdog on cycles with no word moving
  always @(posedge clk) begin
    if ((in_chan.valid === 1'b1 && in_chan.ready === 1'b1) ||
        (out_chan.valid === 1'b1 && out_chan.ready === 1'b1)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
      if (quiet_cycles >= QUIET_LIMIT) begin
        $display("simulation failed");
        $finish;
      end
    end
  end

  initial begin
    rst_n <= 1'b0;
    in_chan.valid <= 1'b0;
    in_chan.data <= '0;
    for (int i = 0; i < CHANNELS; i++) begin
      produced_cnt[i] = '0;
      consumed_cnt[i] = '0;
      waiter_id[i] = NO_TASK;
    end
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_directed_ops();
    test_full_channel();
    test_receiver_backpressure();
    test_random_traffic();
    test_back_to_back();

    wait_for_responses();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (err_count == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

### signal_counter_wake_unit_core.f
hdl/scwu_pkg.sv
hdl/scwu_chan_if.sv
hdl/signal_counter_wake_unit_core.sv
tb/testbench.sv
